// ===== hdl/cip_pkg.sv =====
// Shared constants, status codes and control structs for the checked integer power block.
package cip_pkg;

  localparam int FIELD_BITS    = 64;
  localparam int WORD_BITS_DEF = 64;
  localparam int MUL_BITS      = 32;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NEG_EXP   = 2'd1;
  localparam status_t ST_ZERO_ZERO = 2'd2;
  localparam status_t ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic load;
    logic clr_prod;
    logic mul;
    logic accum;
    logic check;
    logic next_bit;
    logic sel_base;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic early;
    logic exp_msb;
    logic ovf_now;
  } dp_sts_t;

endpackage

// ===== hdl/cip_if.sv =====
// Valid/ready channel interfaces for operand and result transfers.
interface cip_in_if;
  import cip_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] base_value;
  logic [FIELD_BITS-1:0] exponent;
  modport source (output valid, output base_value, output exponent, input ready);
  modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface cip_out_if;
  import cip_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] result_value;
  status_t               status;
  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

// ===== hdl/checked_integer_power.sv =====
// Top level of the checked integer power block: controller, datapath and channel ports.
// Raises a signed base to a signed exponent and returns the exact power with a
// status (ok, negative exponent, zero to the power zero, overflow); the result
// reads zero whenever the status is not ok. One item is in work at a time. A
// negative exponent, a zero exponent, a zero base, a base of magnitude one or an
// exponent of WORD_BITS or more is settled without a scan of the exponent.
// Otherwise the exponent is scanned from its top bit over clog2(WORD_BITS) bit
// positions; each position costs a squaring, plus a multiply by the base when the
// bit is set, and each product is summed from N*N partial products on the one
// 32x32 multiplier, where N = ceil(WORD_BITS/32). An overflow ends the scan
// early. A finished result sits in the output register while the next operand
// transfer is taken.
module checked_integer_power #(
  parameter int WORD_BITS = cip_pkg::WORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  cip_in_if.sink    in_ch,
  cip_out_if.source out_ch
);
  import cip_pkg::*;

  localparam int NCH = (WORD_BITS + MUL_BITS - 1) / MUL_BITS;
  localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;

  ctl_cmd_t       cmd;
  dp_sts_t        sts;
  logic [CIW-1:0] a_idx;
  logic [CIW-1:0] b_idx;

  cip_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd),
    .a_idx     (a_idx),
    .b_idx     (b_idx)
  );

  cip_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .a_idx      (a_idx),
    .b_idx      (b_idx),
    .in_base    (in_ch.base_value),
    .in_exp     (in_ch.exponent),
    .out_value  (out_ch.result_value),
    .out_status (out_ch.status)
  );

endmodule

// ===== hdl/cip_ctrl.sv =====
// Sequencer for square-and-multiply over a shared partial-product multiplier.
module cip_ctrl #(
  parameter int WORD_BITS = cip_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cip_pkg::dp_sts_t  sts,
  output cip_pkg::ctl_cmd_t cmd,
  output logic [((((WORD_BITS + cip_pkg::MUL_BITS - 1) / cip_pkg::MUL_BITS) > 1) ?
                 $clog2((WORD_BITS + cip_pkg::MUL_BITS - 1) / cip_pkg::MUL_BITS) : 1)-1:0]
                            a_idx,
  output logic [((((WORD_BITS + cip_pkg::MUL_BITS - 1) / cip_pkg::MUL_BITS) > 1) ?
                 $clog2((WORD_BITS + cip_pkg::MUL_BITS - 1) / cip_pkg::MUL_BITS) : 1)-1:0]
                            b_idx
);
  import cip_pkg::*;

  localparam int EB   = $clog2(WORD_BITS);
  localparam int BCW  = $clog2(EB);
  localparam int NCH  = (WORD_BITS + MUL_BITS - 1) / MUL_BITS;
  localparam int CIW  = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]     state_r, state_nxt;
  logic           phase_r, phase_nxt;
  logic [BCW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CIW-1:0] ai_r, ai_nxt;
  logic [CIW-1:0] bi_r, bi_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           in_xfer;
  logic           out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign a_idx     = ai_r;
  assign b_idx     = bi_r;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    ai_nxt      = ai_r;
    bi_nxt      = bi_r;
    cmd         = '0;
    cmd.sel_base = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load    = 1'b1;
          phase_nxt   = 1'b0;
          bit_cnt_nxt = BCW'(EB - 1);
          state_nxt   = sts.early ? S_FINISH : S_START;
        end
      end
      S_START: begin
        cmd.clr_prod = 1'b1;
        ai_nxt       = '0;
        bi_nxt       = '0;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = S_MUL;
        if (bi_r == CIW'(NCH - 1)) begin
          bi_nxt = '0;
          if (ai_r == CIW'(NCH - 1)) begin
            state_nxt = S_CHECK;
          end else begin
            ai_nxt = ai_r + CIW'(1);
          end
        end else begin
          bi_nxt = bi_r + CIW'(1);
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.ovf_now) begin
          state_nxt = S_FINISH;
        end else if (!phase_r && sts.exp_msb) begin
          phase_nxt = 1'b1;
          state_nxt = S_START;
        end else if (bit_cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.next_bit = 1'b1;
          bit_cnt_nxt  = bit_cnt_r - BCW'(1);
          phase_nxt    = 1'b0;
          state_nxt    = S_START;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      bit_cnt_r   <= '0;
      ai_r        <= '0;
      bi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      ai_r        <= ai_nxt;
      bi_r        <= bi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/cip_dp.sv =====
// Datapath: operand decode, shared chunked multiplier, range check and result register.
module cip_dp #(
  parameter int WORD_BITS = cip_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  cip_pkg::ctl_cmd_t             cmd,
  output cip_pkg::dp_sts_t              sts,
  input  logic [((((WORD_BITS + cip_pkg::MUL_BITS - 1) / cip_pkg::MUL_BITS) > 1) ?
                 $clog2((WORD_BITS + cip_pkg::MUL_BITS - 1) / cip_pkg::MUL_BITS) : 1)-1:0]
                                        a_idx,
  input  logic [((((WORD_BITS + cip_pkg::MUL_BITS - 1) / cip_pkg::MUL_BITS) > 1) ?
                 $clog2((WORD_BITS + cip_pkg::MUL_BITS - 1) / cip_pkg::MUL_BITS) : 1)-1:0]
                                        b_idx,
  input  logic [cip_pkg::FIELD_BITS-1:0] in_base,
  input  logic [cip_pkg::FIELD_BITS-1:0] in_exp,
  output logic [cip_pkg::FIELD_BITS-1:0] out_value,
  output cip_pkg::status_t              out_status
);
  import cip_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int EB  = $clog2(W);
  localparam int NCH = (W + MUL_BITS - 1) / MUL_BITS;
  localparam int PW  = NCH * MUL_BITS;
  localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [W-1:0] SIGN_W = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]            b_w, e_w, bmag_w, ld_acc, limit, final_w, b_sel;
  logic                    b_neg, e_neg, b_zero, e_zero, bmag_one, e_big, neg_res, early;
  status_t                 ld_st;
  logic [PW-1:0]           a_pad, b_pad;
  logic [MUL_BITS-1:0]     a_ch, b_ch;
  logic [2*MUL_BITS-1:0]   pp;
  logic [2*PW-1:0]         prod_add;
  logic                    ovf_now;

  logic [W-1:0]            bmag_r;
  logic [W-1:0]            acc_r;
  logic [EB-1:0]           exp_r;
  logic                    neg_r;
  status_t                 st_r;
  logic [2*MUL_BITS-1:0]   pp_r;
  logic [CIW:0]            sh_r;
  logic [2*PW-1:0]         prod_r;
  logic [FIELD_BITS-1:0]   out_value_r;
  status_t                 out_status_r;

  always_comb begin
    b_w      = in_base[W-1:0];
    e_w      = in_exp[W-1:0];
    b_neg    = b_w[W-1];
    e_neg    = e_w[W-1];
    b_zero   = (b_w == '0);
    e_zero   = (e_w == '0);
    bmag_w   = b_neg ? (~b_w + W'(1)) : b_w;
    bmag_one = (bmag_w == W'(1));
    e_big    = (e_w >= W'(W));
    neg_res  = b_neg && e_w[0];
    early    = e_neg || e_zero || b_zero || bmag_one || e_big;
    ld_st    = ST_OK;
    ld_acc   = W'(1);
    if (e_neg) begin
      ld_st = ST_NEG_EXP;
    end else if (b_zero && e_zero) begin
      ld_st = ST_ZERO_ZERO;
    end else if (e_zero) begin
      ld_acc = W'(1);
    end else if (b_zero) begin
      ld_acc = '0;
    end else if (bmag_one) begin
      ld_acc = W'(1);
    end else if (e_big) begin
      ld_st = ST_OVERFLOW;
    end
  end

  always_comb begin
    b_sel    = cmd.sel_base ? bmag_r : acc_r;
    a_pad    = PW'(acc_r);
    b_pad    = PW'(b_sel);
    a_ch     = a_pad[a_idx*MUL_BITS +: MUL_BITS];
    b_ch     = b_pad[b_idx*MUL_BITS +: MUL_BITS];
    pp       = (2*MUL_BITS)'(a_ch) * (2*MUL_BITS)'(b_ch);
    prod_add = prod_r + ((2*PW)'(pp_r) << (sh_r * MUL_BITS));
    limit    = neg_r ? SIGN_W : (SIGN_W - W'(1));
    ovf_now  = (|prod_r[2*PW-1:W]) || (prod_r[W-1:0] > limit);
    final_w  = (st_r != ST_OK) ? '0 : (neg_r ? (~acc_r + W'(1)) : acc_r);
  end

  assign sts.early   = early;
  assign sts.exp_msb = exp_r[EB-1];
  assign sts.ovf_now = ovf_now;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bmag_r <= bmag_w;
      exp_r  <= e_w[EB-1:0];
      neg_r  <= neg_res;
      acc_r  <= ld_acc;
      st_r   <= ld_st;
    end
    if (cmd.clr_prod) begin
      prod_r <= '0;
    end
    if (cmd.mul) begin
      pp_r <= pp;
      sh_r <= (CIW+1)'(a_idx) + (CIW+1)'(b_idx);
    end
    if (cmd.accum) begin
      prod_r <= prod_add;
    end
    if (cmd.check) begin
      if (ovf_now) begin
        st_r <= ST_OVERFLOW;
      end else begin
        acc_r <= prod_r[W-1:0];
      end
    end
    if (cmd.next_bit) begin
      exp_r <= exp_r << 1;
    end
    if (cmd.emit) begin
      out_value_r  <= FIELD_BITS'($signed(final_w));
      out_status_r <= st_r;
    end
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ===== hdl/cip_checker.sv =====
// Port-level checks for the checked integer power block and their binding.
module cip_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cip_pkg::FIELD_BITS-1:0] result_value,
  input cip_pkg::status_t              status
);
  import cip_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("result changed or dropped while stalled");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (result_value == '0))
    else $error("nonzero result with failing status");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second operand taken while busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

endmodule

bind checked_integer_power cip_checker u_cip_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_value (out_ch.result_value),
  .status       (out_ch.status)
);
